// ===== rtl/pio_pkg.sv =====
// Shared types and constants for the PC I/O port register block.
// Holds port numbers, CMOS indices, model codes and the store write bundles.
// No dependencies.
package pio_pkg;

   localparam int unsigned CRTC_DEPTH = 32;
   localparam int unsigned CMOS_DEPTH = 64;
   localparam int unsigned CRTC_AW    = $clog2(CRTC_DEPTH);
   localparam int unsigned CMOS_AW    = $clog2(CMOS_DEPTH);

   localparam logic [2:0] MODEL_NONE = 3'd0;
   localparam logic [2:0] MODEL_AT   = 3'd3;

   localparam logic REQ_READ  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   localparam logic [15:0] PORT_PIT_BASE  = 16'h0040;
   localparam logic [15:0] PORT_PIC_MASK  = 16'h0021;
   localparam logic [15:0] PORT_SYS_CTL_B = 16'h0061;
   localparam logic [15:0] PORT_CMOS_IDX  = 16'h0070;
   localparam logic [15:0] PORT_CMOS_DATA = 16'h0071;
   localparam logic [15:0] PORT_CRTC_IDX  = 16'h03D4;
   localparam logic [15:0] PORT_CRTC_DATA = 16'h03D5;

   localparam logic [CMOS_AW-1:0] CMOS_IDX_SEC   = 6'h00;
   localparam logic [CMOS_AW-1:0] CMOS_IDX_MIN   = 6'h02;
   localparam logic [CMOS_AW-1:0] CMOS_IDX_HOUR  = 6'h04;
   localparam logic [CMOS_AW-1:0] CMOS_IDX_WDAY  = 6'h06;
   localparam logic [CMOS_AW-1:0] CMOS_IDX_MDAY  = 6'h07;
   localparam logic [CMOS_AW-1:0] CMOS_IDX_MONTH = 6'h08;
   localparam logic [CMOS_AW-1:0] CMOS_IDX_YEAR  = 6'h09;
   localparam logic [CMOS_AW-1:0] CMOS_IDX_FLOPPY = 6'h10;
   localparam logic [CMOS_AW-1:0] CMOS_IDX_HDD   = 6'h12;
   localparam logic [CMOS_AW-1:0] CMOS_IDX_BASE_LO = 6'h15;
   localparam logic [CMOS_AW-1:0] CMOS_IDX_BASE_HI = 6'h16;
   localparam logic [CMOS_AW-1:0] CMOS_IDX_EXT_LO = 6'h17;
   localparam logic [CMOS_AW-1:0] CMOS_IDX_EXT_HI = 6'h18;

   localparam logic [7:0] CMOS_VAL_FLOPPY  = 8'h44;
   localparam logic [7:0] CMOS_VAL_HDD     = 8'h00;
   localparam logic [7:0] CMOS_VAL_BASE_LO = 8'h80;
   localparam logic [7:0] CMOS_VAL_BASE_HI = 8'h02;
   localparam logic [7:0] CMOS_VAL_EXT_LO  = 8'h00;
   localparam logic [7:0] CMOS_VAL_EXT_HI  = 8'h04;

   localparam logic [7:0] DATA_FLOAT = 8'hFF;

   typedef struct packed {
      logic [2:0]  pad;
      logic [6:0]  now_year_low;
      logic [3:0]  now_month;
      logic [4:0]  now_monthday;
      logic [2:0]  now_weekday;
      logic [4:0]  now_hour;
      logic [5:0]  now_minute;
      logic [5:0]  now_second;
      logic        time_valid;
      logic [7:0]  write_data;
      logic [15:0] port_addr;
   } req_payload_type;

   typedef struct packed {
      logic               en;
      logic [CRTC_AW-1:0] addr;
      logic [7:0]         data;
   } crtc_wr_type;

   typedef struct packed {
      logic               en;
      logic [CMOS_AW-1:0] addr;
      logic [7:0]         data;
   } cmos_wr_type;

endpackage

// ===== rtl/pio_crtc_file.sv =====
// CRTC register file: 32 bytes in flip-flops, cleared by reset.
// One write port and one asynchronous read port at the selected index.
// Depends on pio_pkg.
module pio_crtc_file (
   input  logic                         clock,
   input  logic                         reset,
   input  pio_pkg::crtc_wr_type         wr,
   input  logic [pio_pkg::CRTC_AW-1:0]  rd_addr,
   output logic [7:0]                   rd_data
);

   logic [7:0] regs_ff [pio_pkg::CRTC_DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < int'(pio_pkg::CRTC_DEPTH); i++) begin
            regs_ff[i] <= 8'h00;
         end
      end else if (wr.en) begin
         regs_ff[wr.addr] <= wr.data;
      end
   end

   assign rd_data = regs_ff[rd_addr];

endmodule

// ===== rtl/pio_cmos_ram.sv =====
// CMOS byte store: 64-entry memory with registered read and per-entry valid bits.
// The read port follows the next select value, so rd_data always shows the current entry.
// Depends on pio_pkg.
module pio_cmos_ram (
   input  logic                         clock,
   input  logic                         reset,
   input  pio_pkg::cmos_wr_type         wr,
   input  logic [pio_pkg::CMOS_AW-1:0]  rd_addr,
   output logic [7:0]                   rd_data
);

   logic [7:0]                    mem_ff [pio_pkg::CMOS_DEPTH];
   logic [7:0]                    mem_q_ff;
   logic [pio_pkg::CMOS_DEPTH-1:0] valid_ff;
   logic [pio_pkg::CMOS_DEPTH-1:0] valid_in;
   logic                          vld_q_ff;
   logic                          byp_ff;
   logic [7:0]                    byp_data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         vld_q_ff <= 1'b0;
         byp_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         vld_q_ff <= valid_ff[rd_addr];
         byp_ff   <= wr.en && (wr.addr == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      mem_q_ff    <= mem_ff[rd_addr];
      byp_data_ff <= wr.data;
   end

   assign rd_data = byp_ff ? byp_data_ff : (vld_q_ff ? mem_q_ff : 8'h00);

endmodule

// ===== rtl/pc_io_port_register_block_core.sv =====
// Top level of the PC I/O port register block: input register, port decode, result register.
// Instantiates pio_crtc_file and pio_cmos_ram; depends on pio_pkg.
// One transaction in, one read byte out.

// Each request transaction is held in the input register and then in the result
// register, with decode and store access between them.
// A new transaction is accepted every cycle while the result side keeps up; the CMOS
// memory read is registered and follows the index register, so its data is ready at decode.
// Reset clears the control state, the CRTC file and the CMOS valid bits at once; no clearing pass is needed.
module pc_io_port_register_block_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_data,    // machine_model
   input  logic        req_tvalid,
   output logic        req_tready,
   // port_addr[15:0], write_data[23:16], time_valid[24], now_second[30:25],
   // now_minute[36:31], now_hour[41:37], now_weekday[44:42], now_monthday[49:45],
   // now_month[53:50], now_year_low[60:54], zero[63:61]
   input  logic [63:0] req_tdata,
   input  logic        req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // read_data
);

   logic [2:0]                   model_ff;
   logic                         in_valid_ff;
   pio_pkg::req_payload_type     req_ff;
   logic                         req_type_ff;
   logic                         rsp_valid_ff;
   logic [7:0]                   rsp_data_ff;
   logic [7:0]                   rsp_data_in;
   logic [7:0]                   tick_ff;
   logic [7:0]                   tick_in;
   logic [7:0]                   sys_ctl_ff;
   logic [7:0]                   sys_ctl_in;
   logic [pio_pkg::CRTC_AW-1:0]  crtc_sel_ff;
   logic [pio_pkg::CRTC_AW-1:0]  crtc_sel_in;
   logic [pio_pkg::CMOS_AW-1:0]  cmos_sel_ff;
   logic [pio_pkg::CMOS_AW-1:0]  cmos_sel_in;
   logic                         advance;
   logic                         is_none;
   logic                         is_at;
   logic                         is_write;
   logic [15:0]                  port;
   logic [7:0]                   wdata;
   logic [7:0]                   crtc_rd;
   logic [7:0]                   cmos_rd;
   logic [7:0]                   cmos_val;
   pio_pkg::crtc_wr_type         crtc_wr;
   pio_pkg::cmos_wr_type         cmos_wr;

   assign csr_ready  = 1'b1;
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign is_none  = (model_ff == pio_pkg::MODEL_NONE);
   assign is_at    = (model_ff == pio_pkg::MODEL_AT);
   assign is_write = (req_type_ff == pio_pkg::REQ_WRITE);
   assign port     = req_ff.port_addr;
   assign wdata    = req_ff.write_data;

   always_comb begin
      case (cmos_sel_ff)
         pio_pkg::CMOS_IDX_SEC: begin
            cmos_val = req_ff.time_valid ? {2'b00, req_ff.now_second} : 8'h00;
         end
         pio_pkg::CMOS_IDX_MIN: begin
            cmos_val = req_ff.time_valid ? {2'b00, req_ff.now_minute} : 8'h00;
         end
         pio_pkg::CMOS_IDX_HOUR: begin
            cmos_val = req_ff.time_valid ? {3'b000, req_ff.now_hour} : 8'h00;
         end
         pio_pkg::CMOS_IDX_WDAY: begin
            cmos_val = req_ff.time_valid ? {5'b00000, req_ff.now_weekday} : 8'h00;
         end
         pio_pkg::CMOS_IDX_MDAY: begin
            cmos_val = req_ff.time_valid ? {3'b000, req_ff.now_monthday} : 8'h00;
         end
         pio_pkg::CMOS_IDX_MONTH: begin
            cmos_val = req_ff.time_valid ? {4'b0000, req_ff.now_month} : 8'h00;
         end
         pio_pkg::CMOS_IDX_YEAR: begin
            cmos_val = req_ff.time_valid ? {1'b0, req_ff.now_year_low} : 8'h00;
         end
         pio_pkg::CMOS_IDX_FLOPPY:  cmos_val = pio_pkg::CMOS_VAL_FLOPPY;
         pio_pkg::CMOS_IDX_HDD:     cmos_val = pio_pkg::CMOS_VAL_HDD;
         pio_pkg::CMOS_IDX_BASE_LO: cmos_val = pio_pkg::CMOS_VAL_BASE_LO;
         pio_pkg::CMOS_IDX_BASE_HI: cmos_val = pio_pkg::CMOS_VAL_BASE_HI;
         pio_pkg::CMOS_IDX_EXT_LO:  cmos_val = pio_pkg::CMOS_VAL_EXT_LO;
         pio_pkg::CMOS_IDX_EXT_HI:  cmos_val = pio_pkg::CMOS_VAL_EXT_HI;
         default:                   cmos_val = cmos_rd;
      endcase
   end

   always_comb begin
      tick_in      = tick_ff;
      sys_ctl_in   = sys_ctl_ff;
      crtc_sel_in  = crtc_sel_ff;
      cmos_sel_in  = cmos_sel_ff;
      crtc_wr.en   = 1'b0;
      crtc_wr.addr = crtc_sel_ff;
      crtc_wr.data = wdata;
      cmos_wr.en   = 1'b0;
      cmos_wr.addr = cmos_sel_ff;
      cmos_wr.data = wdata;
      rsp_data_in  = pio_pkg::DATA_FLOAT;
      if (is_write) begin
         rsp_data_in = 8'h00;
         if (advance && !is_none) begin
            if (port == pio_pkg::PORT_SYS_CTL_B) begin
               sys_ctl_in = wdata;
            end else if (port == pio_pkg::PORT_CRTC_IDX) begin
               crtc_sel_in = wdata[pio_pkg::CRTC_AW-1:0];
            end else if (port == pio_pkg::PORT_CRTC_DATA) begin
               crtc_wr.en = 1'b1;
            end else if (port == pio_pkg::PORT_CMOS_IDX && is_at) begin
               cmos_sel_in = wdata[pio_pkg::CMOS_AW-1:0];
            end else if (port == pio_pkg::PORT_CMOS_DATA && is_at) begin
               cmos_wr.en = 1'b1;
            end
         end
      end else if (is_none) begin
         rsp_data_in = pio_pkg::DATA_FLOAT;
      end else if (port[15:2] == pio_pkg::PORT_PIT_BASE[15:2]) begin
         rsp_data_in = tick_ff + 8'd1;
         if (advance) begin
            tick_in = tick_ff + 8'd1;
         end
      end else if (port == pio_pkg::PORT_SYS_CTL_B) begin
         rsp_data_in = sys_ctl_ff;
      end else if (port == pio_pkg::PORT_CRTC_DATA) begin
         rsp_data_in = crtc_rd;
      end else if (port == pio_pkg::PORT_PIC_MASK) begin
         rsp_data_in = 8'h00;
      end else if (port == pio_pkg::PORT_CMOS_DATA && is_at) begin
         rsp_data_in = cmos_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         model_ff     <= pio_pkg::MODEL_NONE;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tick_ff      <= 8'h00;
         sys_ctl_ff   <= 8'h00;
         crtc_sel_ff  <= '0;
         cmos_sel_ff  <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            model_ff <= csr_data;
         end
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         tick_ff     <= tick_in;
         sys_ctl_ff  <= sys_ctl_in;
         crtc_sel_ff <= crtc_sel_in;
         cmos_sel_ff <= cmos_sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_ff      <= pio_pkg::req_payload_type'(req_tdata);
         req_type_ff <= req_tuser;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   pio_crtc_file u_crtc (
      .clock   (clock),
      .reset   (reset),
      .wr      (crtc_wr),
      .rd_addr (crtc_sel_ff),
      .rd_data (crtc_rd)
   );

   pio_cmos_ram u_cmos (
      .clock   (clock),
      .reset   (reset),
      .wr      (cmos_wr),
      .rd_addr (cmos_sel_in),
      .rd_data (cmos_rd)
   );

endmodule
